// File: rtl/lpht_pkg.sv
package lpht_pkg;

	localparam int CAPACITY      = 1024;
	localparam int PAYLOAD_WIDTH = 32;
	localparam int IDX_W         = $clog2(CAPACITY);
	localparam int SIZE_W        = IDX_W + 1;
	localparam int KEY_W         = 32;
	localparam int CNT_W         = 31;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_FIND   = 2'd1;
	localparam logic [1:0] MODE_DELETE = 2'd2;
	localparam logic [1:0] MODE_KICK   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NULL     = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	localparam logic [1:0] REG_TABLE_SIZE = 2'd0;
	localparam logic [1:0] REG_NULL_KEY   = 2'd1;
	localparam logic [1:0] REG_LRU_ENABLE = 2'd2;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef struct packed {
		logic [1:0]               mode;
		logic signed [KEY_W-1:0]  key;
		logic [PAYLOAD_WIDTH-1:0] payload;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic [PAYLOAD_WIDTH-1:0] found_payload;
		logic [9:0]               slot_index;
		logic [10:0]              entry_count;
	} rsp_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [31:0] data;
	} cfg_t;

endpackage

// File: rtl/linear_probe_hash_table_lru.sv
// Open-addressed hash table, 1024 slots of 32-bit signed key and 32-bit payload,
// linear probing with wrap, optional LRU eviction on kick. One request at a time:
// the home index is found by a bit-serial remainder, then a sequencer walks the
// slots, each in a read state and then a compare state. A kick on a full table in
// LRU mode walks the ring a second time to find the least used slot. A null-key
// request skips the remainder and the walk and is answered with ST_NULL. After
// reset and after every write to registers 0 to 2 a clearing pass over all 1024
// slots runs, during which no request is taken. in_stall is high whenever the
// block is busy or a register write is offered; the result waits in an output
// register, held while out_stall is high.
module linear_probe_hash_table_lru (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  lpht_pkg::req_t       in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output lpht_pkg::rsp_t       out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  lpht_pkg::cfg_t       cfg_data
);
	import lpht_pkg::*;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_HASH = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_CMP  = 3'd4;
	localparam logic [2:0] S_WR   = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]  state_q;
	logic [10:0] tsize_q;
	logic [31:0] nkey_q;
	logic        lru_q;

	// memories
	logic [KEY_W-1:0]         keys_m [CAPACITY];
	logic [PAYLOAD_WIDTH-1:0] pays_m [CAPACITY];
	logic [CNT_W-1:0]         cnts_m [CAPACITY];
	logic [KEY_W-1:0]         rkey_q;
	logic [PAYLOAD_WIDTH-1:0] rpay_q;
	logic [CNT_W-1:0]         rcnt_q;

	logic [IDX_W-1:0]  idx_q, home_q, best_q, clr_q;
	logic [SIZE_W-1:0] step_q, n_eff;
	logic [CNT_W-1:0]  bestc_q;
	logic              evict_q;
	req_t              req_q;
	rsp_t              rsp_q;
	logic [10:0]       occ_q;

	// pending write
	logic              we;
	logic [IDX_W-1:0]  wa;
	logic [KEY_W-1:0]  wkey;
	logic [PAYLOAD_WIDTH-1:0] wpay;
	logic [CNT_W-1:0]  wcnt;
	logic              wkey_en, wpay_en;

	logic              div_start, div_done;
	logic [IDX_W-1:0]  div_rem;
	logic [31:0]       mag;
	logic [IDX_W-1:0]  nxt;
	logic              accept;

	assign n_eff = (tsize_q == 11'd0) ? SIZE_W'(1) :
		(tsize_q > 11'(CAPACITY)) ? SIZE_W'(CAPACITY) : SIZE_W'(tsize_q);
	assign mag = req_q.key[31] ? (~req_q.key + 32'd1) : req_q.key;
	assign nxt = ({1'b0, idx_q} + SIZE_W'(1) == n_eff) ? '0 : idx_q + 1'b1;

	// a register write takes priority over a request offered in the same cycle
	assign in_stall  = (state_q != S_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = (state_q == S_OUT);
	assign out_data  = rsp_q;

	lpht_mod u_mod (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(mag),
		.divisor(n_eff), .done(div_done), .rem(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			tsize_q   <= 11'd1024;
			nkey_q    <= '0;
			lru_q     <= 1'b0;
			clr_q     <= '0;
			occ_q     <= '0;
			div_start <= 1'b0;
		end else begin
			div_start <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					occ_q <= '0;
					if (clr_q == IDX_W'(CAPACITY - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cfg_valid && cfg_data.index != 2'd3) begin
						unique case (cfg_data.index)
							REG_TABLE_SIZE: tsize_q <= cfg_data.data[10:0];
							REG_NULL_KEY:   nkey_q  <= cfg_data.data;
							default:        lru_q   <= cfg_data.data[0];
						endcase
						clr_q   <= '0;
						state_q <= S_CLR;
					end else if (accept) begin
						if (in_data.key == nkey_q) begin
							state_q <= S_OUT;
						end else begin
							div_start <= 1'b1;
							state_q   <= S_HASH;
						end
					end
				end
				S_HASH:  if (div_done) state_q <= S_RD;
				S_RD:    state_q <= S_CMP;
				S_CMP:   state_q <= we ? S_OUT : S_RD;
				S_WR:    state_q <= S_OUT;
				S_OUT:   if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_CMP && we && wkey_en) begin
				if (wkey == nkey_q && rkey_q != nkey_q && occ_q != 0) occ_q <= occ_q - 1'b1;
				else if (wkey != nkey_q && rkey_q == nkey_q) occ_q <= occ_q + 1'b1;
			end
		end
	end

	// datapath: decide at S_CMP what to write and the result
	always_comb begin
		we = 1'b0; wkey_en = 1'b0; wpay_en = 1'b0;
		wa = idx_q; wkey = req_q.key; wpay = req_q.payload; wcnt = '0;
		if (state_q == S_CMP) begin
			if (evict_q) begin
				if (step_q == n_eff) begin
					// the last slot of the walk is still in rcnt_q
					we = 1'b1; wkey_en = 1'b1; wpay_en = 1'b1;
					wa = (rcnt_q < bestc_q) ? idx_q : best_q;
				end
			end else if (req_q.mode == MODE_INSERT || req_q.mode == MODE_KICK) begin
				if (rkey_q == nkey_q) begin
					we = 1'b1; wkey_en = 1'b1; wpay_en = 1'b1; wcnt = rcnt_q;
				end else if (step_q == n_eff && req_q.mode == MODE_INSERT) begin
					we = 1'b1;
					wcnt = rcnt_q;
				end
			end else begin
				if (rkey_q == req_q.key) begin
					we = 1'b1;
					if (req_q.mode == MODE_FIND) begin
						wcnt = (lru_q && rcnt_q != CNT_MAX) ? rcnt_q + 1'b1 : rcnt_q;
					end else begin
						wkey_en = 1'b1; wkey = nkey_q;
					end
				end else if (step_q == n_eff) begin
					we = 1'b1; wcnt = rcnt_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CLR) begin
			keys_m[clr_q] <= nkey_q;
			cnts_m[clr_q] <= '0;
		end else if (we) begin
			if (wkey_en) keys_m[wa] <= wkey;
			if (wpay_en) pays_m[wa] <= wpay;
			cnts_m[wa] <= wcnt;
		end
		rkey_q <= keys_m[idx_q];
		rpay_q <= pays_m[idx_q];
		rcnt_q <= cnts_m[idx_q];

		if (accept) begin
			req_q   <= in_data;
			evict_q <= 1'b0;
			rsp_q   <= '{ST_NULL, '0, '0, occ_q};
		end
		if (state_q == S_HASH && div_done) begin
			idx_q  <= div_rem;
			home_q <= div_rem;
			best_q <= div_rem;
			step_q <= SIZE_W'(1);
		end
		if (state_q == S_CMP) begin
			if (evict_q && (step_q == SIZE_W'(1) || rcnt_q < bestc_q)) begin
				best_q  <= idx_q;
				bestc_q <= rcnt_q;
			end
			if (!we) begin
				// kick on a full ring: in LRU mode rescan for least counter, else evict the home slot
				if (!evict_q && req_q.mode == MODE_KICK && step_q == n_eff) begin
					evict_q <= 1'b1;
					idx_q   <= home_q;
					best_q  <= home_q;
					step_q  <= lru_q ? SIZE_W'(1) : n_eff;
				end else begin
					idx_q  <= nxt;
					step_q <= step_q + 1'b1;
				end
			end else begin
				if (evict_q) begin
					rsp_q <= '{ST_OK, '0, 10'(wa), occ_q};
				end else if (req_q.mode == MODE_INSERT || req_q.mode == MODE_KICK) begin
					if (rkey_q == nkey_q) rsp_q <= '{ST_OK, '0, 10'(wa), occ_q + 11'd1};
					else rsp_q <= '{ST_FULL, '0, '0, occ_q};
				end else if (rkey_q == req_q.key) begin
					if (req_q.mode == MODE_FIND) begin
						rsp_q <= '{ST_OK, rpay_q, 10'(wa), occ_q};
					end else begin
						rsp_q <= '{ST_OK, '0, 10'(wa),
							(occ_q != 0) ? occ_q - 11'd1 : occ_q};
					end
				end else begin
					rsp_q <= '{ST_NOTFOUND, '0, '0, occ_q};
				end
			end
		end
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("stall low while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("result changed under stall");
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= 11'(CAPACITY)) else $error("occupancy overflow");
endmodule

// File: rtl/lpht_mod.sv
// Iterative remainder: one quotient bit per cycle, restoring.
module lpht_mod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [31:0]                dividend,
	input  logic [lpht_pkg::SIZE_W-1:0] divisor,
	output logic                       done,
	output logic [lpht_pkg::IDX_W-1:0]  rem
);
	import lpht_pkg::*;

	logic [5:0]        cnt_q;
	logic              busy_q;
	logic [31:0]       dvd_q;
	logic [SIZE_W:0]   rem_q;
	logic [SIZE_W:0]   trial;

	assign trial = {rem_q[SIZE_W-1:0], dvd_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (trial >= {1'b0, divisor}) rem_q <= trial - {1'b0, divisor};
			else rem_q <= trial;
		end
	end

	assign rem = rem_q[IDX_W-1:0];
endmodule
